// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of the palette block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk and switched off while rst_n is low.
`define BPRC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("palette block assertion failed");

// Concurrent assertion sampled on clk that also holds during reset.
`define BPRC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("palette block assertion failed during reset");

`endif

// ----- rtl/core/bprc_pkg.sv -----
// Types and constants shared by the banked palette RAM modules.
package bprc_pkg;

    localparam int INDEX_W = 12;
    localparam int BYTE_ADDR_W = 13;
    localparam int DATA_W = 16;
    localparam int CHAN_W = 8;

    typedef enum logic [1:0] {
        FUNC_WRITE_BYTE  = 2'd0,
        FUNC_WRITE_WORD  = 2'd1,
        FUNC_SELECT_BANK = 2'd2,
        FUNC_LOOKUP      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ACCESS,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic set_bank;
        logic reduce;
        logic wr_hi;
        logic wr_lo;
        logic rd;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  odd;
        logic  out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/bprc_ram.sv -----
// Generic single-port RAM with a registered read.
module bprc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bprc_ctrl.sv -----
// Controller state machine that sequences each transaction through the datapath.
module bprc_ctrl import bprc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] func,
    input  dp_status_t stat,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    func_t       in_func;

    assign in_func = func_t'(func);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_func != FUNC_SELECT_BANK))
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (stat.func == FUNC_LOOKUP)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
                cmd.set_bank = in_valid && (in_func == FUNC_SELECT_BANK);
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
            end
            ST_ACCESS:
            begin
                case (stat.func)
                    FUNC_WRITE_BYTE:
                    begin
                        cmd.wr_hi = !stat.odd;
                        cmd.wr_lo = stat.odd;
                    end
                    FUNC_WRITE_WORD:
                    begin
                        cmd.wr_hi = 1'b1;
                        cmd.wr_lo = 1'b1;
                    end
                    FUNC_LOOKUP:
                    begin
                        cmd.rd = 1'b1;
                    end
                    default:
                    begin
                        cmd.rd = 1'b0;
                    end
                endcase
            end
            ST_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/bprc_datapath.sv -----
// Datapath: item registers, index reduction, bank select, palette RAMs and output register.
module bprc_datapath import bprc_pkg::*; #(
    parameter int ENTRIES_PER_BANK = 4096,
    parameter int BANK_COUNT = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             stat,
    input  logic [1:0]             func,
    input  logic [BYTE_ADDR_W-1:0] byte_address,
    input  logic [DATA_W-1:0]      write_data,
    input  logic                   new_bank,
    input  logic [INDEX_W-1:0]     colour_index,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [CHAN_W-1:0]      red,
    output logic [CHAN_W-1:0]      green,
    output logic [CHAN_W-1:0]      blue
);

    localparam int RECIP = (1 << INDEX_W) / ENTRIES_PER_BANK;
    localparam int RW = (RECIP > 0) ? $clog2(RECIP + 1) : 1;
    localparam int PW = INDEX_W + RW;
    localparam int IW = $clog2(ENTRIES_PER_BANK);
    localparam int DEPTH = BANK_COUNT * ENTRIES_PER_BANK;
    localparam int AW = $clog2(DEPTH);
    localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    func_t               func_reg;
    func_t               func_next;
    logic                odd_reg;
    logic                odd_next;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   data_next;
    logic [INDEX_W-1:0]  idx_reg;
    logic [INDEX_W-1:0]  idx_next;
    logic [PW-1:0]       prod_reg;
    logic [PW-1:0]       prod_next;
    logic [IW-1:0]       word_reg;
    logic [IW-1:0]       word_next;
    logic [BW-1:0]       bank_reg;
    logic [BW-1:0]       bank_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   red_next;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   green_next;
    logic [CHAN_W-1:0]   blue_reg;
    logic [CHAN_W-1:0]   blue_next;

    func_t               in_func;
    logic [INDEX_W-1:0]  idx_src;
    logic [RW-1:0]       quot_est;
    logic [31:0]         quot_mul;
    logic [INDEX_W-1:0]  rem_raw;
    logic [INDEX_W-1:0]  rem_fix;
    logic [AW-1:0]       slot;
    logic [7:0]          wdata_hi;
    logic [7:0]          wdata_lo;
    logic [7:0]          rdata_hi;
    logic [7:0]          rdata_lo;
    logic [DATA_W-1:0]   colour;
    logic                out_free;

    assign in_func = func_t'(func);

    // Writes address the word at byte_address / 2; lookups use the colour index.
    always_comb
    begin
        if ((in_func == FUNC_WRITE_BYTE) || (in_func == FUNC_WRITE_WORD))
        begin
            idx_src = byte_address[BYTE_ADDR_W-1:1];
        end
        else
        begin
            idx_src = colour_index;
        end
    end

    // The index is wrapped into the bank by a reciprocal multiply, one
    // back-multiply and one conditional subtract.
    assign quot_est = prod_reg[PW-1:INDEX_W];
    assign quot_mul = 32'(quot_est) * 32'(ENTRIES_PER_BANK);
    assign rem_raw = idx_reg - quot_mul[INDEX_W-1:0];

    always_comb
    begin
        if (32'(rem_raw) >= 32'(ENTRIES_PER_BANK))
        begin
            rem_fix = rem_raw - INDEX_W'(ENTRIES_PER_BANK);
        end
        else
        begin
            rem_fix = rem_raw;
        end
    end

    assign slot = AW'(AW'(bank_reg) * AW'(ENTRIES_PER_BANK)) + AW'(word_reg);

    always_comb
    begin
        func_next = func_reg;
        odd_next = odd_reg;
        data_next = data_reg;
        idx_next = idx_reg;
        prod_next = prod_reg;
        word_next = word_reg;
        if (cmd.capture)
        begin
            func_next = in_func;
            odd_next = byte_address[0];
            data_next = write_data;
            idx_next = idx_src;
            prod_next = PW'(idx_src) * PW'(RECIP);
        end
        if (cmd.reduce)
        begin
            word_next = IW'(rem_fix);
        end
    end

    always_comb
    begin
        bank_next = bank_reg;
        if (cmd.set_bank)
        begin
            if (BANK_COUNT > 1)
            begin
                bank_next = BW'(new_bank);
            end
            else
            begin
                bank_next = '0;
            end
        end
    end

    always_comb
    begin
        if (func_reg == FUNC_WRITE_WORD)
        begin
            wdata_hi = data_reg[15:8];
        end
        else
        begin
            wdata_hi = data_reg[7:0];
        end
        wdata_lo = data_reg[7:0];
    end

    bprc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram_hi (
        .clk  (clk),
        .we   (cmd.wr_hi),
        .re   (cmd.rd),
        .addr (slot),
        .wdata(wdata_hi),
        .rdata(rdata_hi)
    );

    bprc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram_lo (
        .clk  (clk),
        .we   (cmd.wr_lo),
        .re   (cmd.rd),
        .addr (slot),
        .wdata(wdata_lo),
        .rdata(rdata_lo)
    );

    assign colour = {rdata_hi, rdata_lo};
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        red_next = red_reg;
        green_next = green_reg;
        blue_next = blue_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            red_next = {colour[11:8], colour[14], 3'b000};
            green_next = {colour[7:4], colour[13], 3'b000};
            blue_next = {colour[3:0], colour[12], 3'b000};
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bank_reg <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        odd_reg <= odd_next;
        data_reg <= data_next;
        idx_reg <= idx_next;
        prod_reg <= prod_next;
        word_reg <= word_next;
        red_reg <= red_next;
        green_reg <= green_next;
        blue_reg <= blue_next;
    end

    assign stat.func = func_reg;
    assign stat.odd = odd_reg;
    assign stat.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

endmodule

// ----- rtl/core/banked_palette_ram_rgb_convert.sv -----
// Top level of the banked palette RAM with RGB conversion.
//
// The input channel (in_valid, in_ready) carries one transaction per handshake:
// a byte write, a word write, a bank select, or a colour lookup chosen by func.
// The output channel (out_valid, out_ready) carries red, green and blue for each
// lookup; other transactions produce nothing on it.
// A bank select leaves the controller idle, so input stays ready. A write passes
// through the reduction and access steps, and a lookup also through the result
// step, before the next transaction can be accepted. This follows the controller
// sequence: an index reduction step, one access to the palette RAM port and, for a
// lookup, a step to register the converted colour, which then appears on out_valid.
// The result sits in an output register, so new transactions are taken while it
// waits. When the receiver stalls with a result still held, the next lookup waits
// in its final step until the register frees, and input is held off meanwhile.
// Reset clears the controller, the output valid flag and the active bank (bank 0).
// Palette contents are not cleared and must be written before they are read.
module banked_palette_ram_rgb_convert import bprc_pkg::*; #(
    parameter int ENTRIES_PER_BANK = 4096,
    parameter int BANK_COUNT = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [BYTE_ADDR_W-1:0] byte_address,
    input  logic [DATA_W-1:0]      write_data,
    input  logic                   new_bank,
    input  logic [INDEX_W-1:0]     colour_index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAN_W-1:0]      red,
    output logic [CHAN_W-1:0]      green,
    output logic [CHAN_W-1:0]      blue
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    bprc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .func    (func),
        .stat    (stat),
        .in_ready(in_ready),
        .cmd     (cmd)
    );

    bprc_datapath #(
        .ENTRIES_PER_BANK(ENTRIES_PER_BANK),
        .BANK_COUNT      (BANK_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .byte_address(byte_address),
        .write_data  (write_data),
        .new_bank    (new_bank),
        .colour_index(colour_index),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

endmodule

// ----- rtl/core/bprc_checker.sv -----
// Port-level checker for the banked palette RAM, bound to the top level.
`include "assert_macros.svh"

module bprc_checker import bprc_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] func,
    input logic       out_valid,
    input logic       out_ready
);

    `BPRC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
    `BPRC_ASSERT(a_busy_after_access, in_valid && in_ready && (func != FUNC_SELECT_BANK) |=> !in_ready ##1 !in_ready)
    `BPRC_ASSERT(a_select_single_cycle, in_valid && in_ready && (func == FUNC_SELECT_BANK) |=> in_ready)
    `BPRC_ASSERT(a_lookup_result, in_valid && in_ready && (func == FUNC_LOOKUP) |-> ##4 out_valid)
    `BPRC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind banked_palette_ram_rgb_convert bprc_checker u_bprc_checker (.*);
